@@ hdl/swsd_pkg.sv @@
// Package for the sliding-window spread detector: sizes, register codes,
// queue entry layout, state machine types and inter-module structs.
// Depends on nothing; every other file of the block but swsd_ram imports it.
`default_nettype none
package swsd_pkg;

  localparam int WINDOW_MAX    = 4096;
  localparam int SAMPLE_BITS   = 20;
  localparam int SLOT_BITS     = $clog2(WINDOW_MAX);
  localparam int LEN_BITS      = SLOT_BITS + 1;
  localparam int WLEN_BITS     = 13;
  localparam int LIMIT_BITS    = 20;
  localparam int CFG_DATA_BITS = 20;
  localparam int COUNT_BITS    = 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH,
    REG_SPREAD_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
    logic [LEN_BITS-1:0]    len;
  } item_t;

  typedef struct packed {
    logic [FIFO_PTR_BITS:0] fill;
  } fr_stat_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]   slot;
    logic [SAMPLE_BITS-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic                   start;
    logic                   ack;
    logic                   restart;
    logic [SLOT_BITS-1:0]   slot;
    logic [SAMPLE_BITS-1:0] value;
    logic [LEN_BITS-1:0]    len;
  } q_cmd_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] front_value;
  } q_stat_t;

  typedef enum logic [3:0] {
    Q_IDLE,
    Q_EV1_RD,
    Q_EV1_CHK,
    Q_BK_RD,
    Q_BK_CHK,
    Q_PUSH,
    Q_EV2_RD,
    Q_EV2_CHK,
    Q_DONE
  } q_state_t;

  typedef enum logic [0:0] {
    B_IDLE,
    B_RUN
  } b_state_t;

endpackage
`default_nettype wire

@@ hdl/swsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module swsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/swsd_front.sv @@
// Front part: takes requests, clamps the window length for each one and
// holds them in a two-entry queue for the back part. Depends on swsd_pkg.
`default_nettype none
module swsd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [swsd_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic                             last_sample,
  input  logic [swsd_pkg::WLEN_BITS-1:0]   window_length,
  output logic                             item_valid,
  output swsd_pkg::item_t                  item,
  input  logic                             item_ready,
  output swsd_pkg::fr_stat_t               stat
);
  import swsd_pkg::*;

  item_t                  fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_PTR_BITS:0]   fill;
  logic [LEN_BITS-1:0]      eff_len;
  logic                     push;
  logic                     pop;

  // Zero means one; anything beyond the ring depth means the full ring.
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      eff_len = LEN_BITS'(WINDOW_MAX);
    end else begin
      eff_len = LEN_BITS'(window_length);
    end
  end

  assign in_ready   = (fill != (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
  assign item_valid = (fill != '0);
  assign item       = fifo_mem[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;
  assign stat.fill  = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      if (push && !pop) begin
        fill <= fill + (FIFO_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (FIFO_PTR_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{sample: sample_value, last: last_sample, len: eff_len};
    end
  end
endmodule
`default_nettype wire

@@ hdl/swsd_mono_queue.sv @@
// Monotonic queue of (slot, value) entries kept in a RAM: evicts old entries
// at the front, drops dominated ones at the back, pushes the new sample and
// reports the front value. Depends on swsd_pkg and swsd_ram.
`default_nettype none
module swsd_mono_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              is_max,
  input  swsd_pkg::q_cmd_t  cmd,
  output swsd_pkg::q_stat_t stat
);
  import swsd_pkg::*;

  q_state_t               state;
  q_state_t               state_next;
  logic [SLOT_BITS-1:0]   head;
  logic [LEN_BITS-1:0]    count;
  logic [SLOT_BITS-1:0]   slot_r;
  logic [SAMPLE_BITS-1:0] value_r;
  logic [LEN_BITS-1:0]    len_r;
  logic                   first_r;
  logic [SAMPLE_BITS-1:0] front_r;

  q_entry_t             rd_entry;
  q_entry_t             wr_entry;
  logic [SLOT_BITS-1:0] raddr;
  logic [SLOT_BITS-1:0] back_addr;
  logic [SLOT_BITS-1:0] push_addr;
  logic [SLOT_BITS-1:0] age;
  logic [LEN_BITS-1:0]  len_m1;
  logic                 old_hit;
  logic                 new_hit;
  logic                 dominated;
  logic                 empty;
  logic                 we;
  logic                 pop_front;
  logic                 pop_back;
  logic                 cap_front;
  logic                 clear;

  assign empty     = (count == '0);
  assign back_addr = head + count[SLOT_BITS-1:0] - SLOT_BITS'(1);
  assign push_addr = head + count[SLOT_BITS-1:0];
  assign age       = slot_r - rd_entry.slot;
  assign len_m1    = len_r - LEN_BITS'(1);
  assign old_hit   = ({1'b0, age} >= len_r);
  assign new_hit   = ({1'b0, age} >= len_m1);
  assign dominated = is_max ? (rd_entry.value <= value_r) : (rd_entry.value >= value_r);
  assign wr_entry  = '{slot: slot_r, value: value_r};

  swsd_ram #(
    .WIDTH($bits(q_entry_t)),
    .DEPTH(WINDOW_MAX)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(push_addr),
    .wdata(wr_entry),
    .raddr(raddr),
    .rdata(rd_entry)
  );

  always_comb begin
    state_next = state;
    case (state)
      Q_IDLE:    if (cmd.start) state_next = Q_EV1_RD;
      Q_EV1_RD:  state_next = empty ? Q_BK_RD : Q_EV1_CHK;
      Q_EV1_CHK: state_next = old_hit ? Q_EV1_RD : Q_BK_RD;
      Q_BK_RD:   state_next = empty ? Q_PUSH : Q_BK_CHK;
      Q_BK_CHK:  state_next = dominated ? Q_BK_RD : Q_PUSH;
      Q_PUSH:    state_next = Q_EV2_RD;
      Q_EV2_RD:  state_next = empty ? Q_DONE : Q_EV2_CHK;
      Q_EV2_CHK: state_next = new_hit ? Q_EV2_RD : Q_DONE;
      Q_DONE:    if (cmd.ack) state_next = Q_IDLE;
      default:   state_next = Q_IDLE;
    endcase
  end

  always_comb begin
    raddr     = head;
    we        = 1'b0;
    pop_front = 1'b0;
    pop_back  = 1'b0;
    cap_front = 1'b0;
    clear     = 1'b0;
    case (state)
      Q_EV1_CHK: pop_front = old_hit;
      Q_BK_RD:   raddr = back_addr;
      Q_BK_CHK:  pop_back = dominated;
      Q_PUSH:    we = (count < LEN_BITS'(WINDOW_MAX));
      Q_EV2_CHK: begin
        pop_front = new_hit;
        cap_front = first_r;
      end
      Q_DONE:    clear = cmd.ack && cmd.restart;
      default:   raddr = head;
    endcase
  end

  assign stat.done        = (state == Q_DONE);
  assign stat.front_value = front_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= Q_IDLE;
      head    <= '0;
      count   <= '0;
      first_r <= 1'b0;
    end else begin
      state <= state_next;
      if (clear) begin
        head  <= '0;
        count <= '0;
      end else if (pop_front) begin
        head  <= head + SLOT_BITS'(1);
        count <= count - LEN_BITS'(1);
      end else if (pop_back) begin
        count <= count - LEN_BITS'(1);
      end else if (we) begin
        count <= count + LEN_BITS'(1);
      end
      if (state == Q_PUSH) begin
        first_r <= 1'b1;
      end else if (cap_front) begin
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == Q_IDLE && cmd.start) begin
      slot_r  <= cmd.slot;
      value_r <= cmd.value;
      len_r   <= cmd.len;
    end
    if (cap_front) begin
      front_r <= rd_entry.value;
    end
  end
endmodule
`default_nettype wire

@@ hdl/swsd_back.sv @@
// Back part: runs the maximum and minimum queues for one request, checks the
// window spread and holds the result in an output register.
// Depends on swsd_pkg and swsd_mono_queue.
`default_nettype none
module swsd_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  swsd_pkg::item_t                  item,
  output logic                             item_ready,
  input  logic [swsd_pkg::LIMIT_BITS-1:0]  spread_limit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [swsd_pkg::COUNT_BITS-1:0]  start_position,
  output logic                             none_found
);
  import swsd_pkg::*;

  b_state_t              state;
  b_state_t              state_next;
  logic [SLOT_BITS-1:0]  write_slot;
  logic [COUNT_BITS-1:0] sample_count;
  logic                  any_match;
  logic                  last_r;
  logic [LEN_BITS-1:0]   len_r;

  q_cmd_t                cmd;
  q_stat_t               max_stat;
  q_stat_t               min_stat;
  logic                  finish;
  logic [COUNT_BITS-1:0] count_inc;
  logic [SAMPLE_BITS:0]  diff;
  logic                  quiet;
  logic                  match;
  logic                  none;
  logic                  emit;
  logic [COUNT_BITS-1:0] pos;

  swsd_mono_queue u_max_q (
    .clk   (clk),
    .rst   (rst),
    .is_max(1'b1),
    .cmd   (cmd),
    .stat  (max_stat)
  );

  swsd_mono_queue u_min_q (
    .clk   (clk),
    .rst   (rst),
    .is_max(1'b0),
    .cmd   (cmd),
    .stat  (min_stat)
  );

  assign finish    = (state == B_RUN) && max_stat.done && min_stat.done
                     && (!out_valid || out_ready);
  assign count_inc = (sample_count == COUNT_MAX) ? sample_count
                     : sample_count + COUNT_BITS'(1);
  assign diff      = {1'b0, max_stat.front_value} - {1'b0, min_stat.front_value};
  assign quiet     = !diff[SAMPLE_BITS] && (32'(diff[SAMPLE_BITS-1:0]) <= 32'(spread_limit));
  assign match     = (count_inc >= COUNT_BITS'(len_r)) && quiet;
  assign none      = last_r && !match && !any_match;
  assign emit      = finish && (match || none);
  assign pos       = count_inc - COUNT_BITS'(len_r) + COUNT_BITS'(1);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (item_valid) state_next = B_RUN;
      B_RUN:   if (finish) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    item_ready  = (state == B_IDLE);
    cmd.start   = (state == B_IDLE) && item_valid;
    cmd.ack     = finish;
    cmd.restart = last_r;
    cmd.slot    = write_slot;
    cmd.value   = item.sample;
    cmd.len     = item.len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      write_slot   <= '0;
      sample_count <= '0;
      any_match    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        write_slot <= write_slot + SLOT_BITS'(1);
        if (last_r) begin
          sample_count <= '0;
          any_match    <= 1'b0;
        end else begin
          sample_count <= count_inc;
          any_match    <= any_match || match;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      last_r <= item.last;
      len_r  <= item.len;
    end
    if (emit) begin
      start_position <= match ? pos : '0;
      none_found     <= !match;
    end
  end
endmodule
`default_nettype wire

@@ hdl/sliding_window_spread_detector_top.sv @@
// Sliding-window spread detector. Each request carries one unsigned sample;
// after every sample that completes a window of window_length samples the
// block returns the window's 1-based start position if the window's maximum
// minus minimum is at most spread_limit, and on the sample marked last it
// returns a none result if no window of the stream matched. A request takes
// longer for every entry popped from the two RAM-held monotonic queues, which
// read entries with registered data; the back part takes one request at a time.
// Depends on swsd_pkg, swsd_front and swsd_back.
`default_nettype none
module sliding_window_spread_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swsd_pkg::SAMPLE_BITS-1:0]    sample_value,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swsd_pkg::COUNT_BITS-1:0]     start_position,
  output logic                                none_found,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  swsd_pkg::cfg_reg_t                  cfg_index,
  input  logic [swsd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import swsd_pkg::*;

  // Configuration registers. Writes are always taken; the user writes them
  // only while no request is in flight.
  logic [WLEN_BITS-1:0]  window_length;
  logic [LIMIT_BITS-1:0] spread_limit;

  logic     item_valid;
  logic     item_ready;
  item_t    item;
  fr_stat_t fr_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_BITS'(1);
      spread_limit  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[WLEN_BITS-1:0];
        REG_SPREAD_LIMIT:  spread_limit  <= cfg_data[LIMIT_BITS-1:0];
        default:           spread_limit  <= spread_limit;
      endcase
    end
  end

  // The front queues requests so the sender is not held while the back
  // part walks its queues, unless the request queue is full.
  swsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .window_length(window_length),
    .item_valid   (item_valid),
    .item         (item),
    .item_ready   (item_ready),
    .stat         (fr_stat)
  );

  // The back part owns the queues, the position count and the result register.
  swsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .item_ready    (item_ready),
    .spread_limit  (spread_limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .start_position(start_position),
    .none_found    (none_found)
  );

  // The request queue never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fr_stat.fill) <= FIFO_DEPTH)
    else $error("request queue overfilled");

  // An accepted request is held in the queue in the following cycle.
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> fr_stat.fill != '0)
    else $error("accepted request lost");

  // A none result never carries a position.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_found |-> start_position == '0)
    else $error("none result with a position");
endmodule
`default_nettype wire
